// File: src/camh_pkg.sv
// Shared types, constants and codes of the code address map hash table.
package camh_pkg;

    // Field widths fixed by the item format.
    localparam int FIELD_W = 32;
    localparam int CFG_W   = 11;

    // Defaults for the top level parameters.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ADDR_WIDTH_DEF  = 32;

    // Probe limit after reset.
    localparam logic [CFG_W-1:0] PROBE_LIMIT_RESET = CFG_W'(102);

    // Command codes.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Request beat.
    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] source_address;
        logic [FIELD_W-1:0] target_address;
    } t_req;

    // Response beat.
    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] result_address;
        logic               status;
    } t_rsp;

    // Table read address select.
    typedef enum logic {
        RD_HOME,
        RD_NEXT
    } t_rd_sel;

    // Table write select.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_INSERT,
        WR_SWAP_HOME,
        WR_SWAP_SLOT
    } t_wr_sel;

    // Kind of response to build.
    typedef enum logic [1:0] {
        OUT_OK,
        OUT_HIT,
        OUT_FULL
    } t_out_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_req;
        logic      probe_start;
        logic      probe;
        logic      probe_adv;
        logic      cap_hit;
        t_rd_sel   rd_sel;
        t_wr_sel   wr_sel;
        logic      out_load;
        t_out_kind out_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic src_zero;
        logic is_insert;
        logic empty;
        logic match;
        logic at_home;
        logic last_lookup;
        logic insert_stop;
        logic clr_last;
    } t_dp_sts;

endpackage

// File: src/camh_stream_if.sv
// Valid/ready stream interface that carries one payload beat.
interface camh_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/camh_ram.sv
// Generic single write port, single read port RAM with registered read data.
module camh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/camh_dp.sv
// Datapath: request registers, home slot hash pipeline, table memory and probe state.
module camh_dp #(
    parameter int TABLE_DEPTH = camh_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = camh_pkg::ADDR_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [camh_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  camh_pkg::t_req               i_req_data,
    input  camh_pkg::t_dp_cmd            i_cmd,
    output camh_pkg::t_dp_sts            o_sts,
    output camh_pkg::t_rsp               o_rsp_data
);

    // Stored key width: addresses keep ADDR_WIDTH bits and never more than a field.
    localparam int KEY_W  = (ADDR_WIDTH < camh_pkg::FIELD_W) ? ADDR_WIDTH : camh_pkg::FIELD_W;
    localparam int ENT_W  = 2 * KEY_W;
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int XW     = KEY_W - 2;
    localparam int PW1    = 2 * XW;
    localparam int PW2    = XW + SLOT_W + 1;
    localparam int W2     = (XW > SLOT_W + 1) ? XW : SLOT_W + 1;
    localparam int CMP_W  = (SLOT_W + 1 > camh_pkg::CFG_W) ? SLOT_W + 1 : camh_pkg::CFG_W;
    // Reciprocal of the depth, scaled by 2^XW; the estimate it gives is low by at most one.
    localparam logic [XW-1:0] HASH_MUL = XW'((64'd1 << XW) / TABLE_DEPTH);

    logic                       r_cmd;
    logic [KEY_W-1:0]           r_src;
    logic [KEY_W-1:0]           r_dst;
    logic [PW1-1:0]             r_prod1;
    logic [XW-1:0]              r_prod2;
    logic [SLOT_W-1:0]          r_home;
    logic [SLOT_W-1:0]          r_slot;
    logic [SLOT_W-1:0]          r_count;
    logic [SLOT_W-1:0]          r_clr;
    logic [ENT_W-1:0]           r_home_ent;
    logic [KEY_W-1:0]           r_hit_dst;
    logic [camh_pkg::CFG_W-1:0] r_limit;
    camh_pkg::t_rsp             r_out;

    logic [XW-1:0]     hash_x;
    logic [PW2-1:0]    prod2_full;
    logic [XW-1:0]     rem_raw;
    logic [W2-1:0]     rem_wide;
    logic [W2-1:0]     rem_fix;
    logic [SLOT_W-1:0] slot_next;
    logic [CMP_W-1:0]  count_inc;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    logic [ENT_W-1:0]  mem_rdata;
    logic [KEY_W-1:0]  rd_src;
    logic [KEY_W-1:0]  rd_dst;

    // Home slot: (source >> 2) mod depth by reciprocal multiply and one correction.
    assign hash_x     = r_src[KEY_W-1:2];
    assign prod2_full = PW2'(r_prod1[PW1-1:XW]) * PW2'(TABLE_DEPTH);
    assign rem_raw    = hash_x - r_prod2;
    assign rem_wide   = W2'(rem_raw);
    assign rem_fix    = (rem_wide >= W2'(TABLE_DEPTH)) ? (rem_wide - W2'(TABLE_DEPTH))
                                                       : rem_wide;

    // Request capture and the hash pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_cmd <= i_req_data.command;
            r_src <= i_req_data.source_address[KEY_W-1:0];
            r_dst <= i_req_data.target_address[KEY_W-1:0];
        end
        r_prod1 <= PW1'(hash_x) * PW1'(HASH_MUL);
        r_prod2 <= prod2_full[XW-1:0];
        r_home  <= rem_fix[SLOT_W-1:0];
    end

    // Probe position, wrapping at the end of the table.
    assign slot_next = (r_slot == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_start) begin
            r_slot  <= r_home;
            r_count <= '0;
        end else if (i_cmd.probe_adv) begin
            r_slot  <= slot_next;
            r_count <= r_count + 1'b1;
        end
        // The first probe reads the home entry; keep it for a swap.
        if (i_cmd.probe && (r_count == '0)) begin
            r_home_ent <= mem_rdata;
        end
        if (i_cmd.cap_hit) begin
            r_hit_dst <= rd_dst;
        end
    end

    // Clearing pointer and probe limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_limit <= camh_pkg::PROBE_LIMIT_RESET;
        end else begin
            if (i_cmd.wr_sel == camh_pkg::WR_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Table read and write address selection.
    always_comb begin
        mem_raddr = (i_cmd.rd_sel == camh_pkg::RD_HOME) ? r_home : slot_next;
        mem_we    = 1'b1;
        mem_waddr = r_slot;
        mem_wdata = {r_src, r_dst};
        case (i_cmd.wr_sel)
            camh_pkg::WR_CLEAR: begin
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            camh_pkg::WR_INSERT: begin
                mem_waddr = r_slot;
                mem_wdata = {r_src, r_dst};
            end
            camh_pkg::WR_SWAP_HOME: begin
                mem_waddr = r_home;
                mem_wdata = mem_rdata;
            end
            camh_pkg::WR_SWAP_SLOT: begin
                mem_waddr = r_slot;
                mem_wdata = r_home_ent;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    camh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_src = mem_rdata[ENT_W-1:KEY_W];
    assign rd_dst = mem_rdata[KEY_W-1:0];

    // Status toward the controller.
    assign count_inc         = CMP_W'(r_count) + 1'b1;
    assign o_sts.src_zero    = (r_src == '0);
    assign o_sts.is_insert   = (r_cmd == camh_pkg::CMD_INSERT);
    assign o_sts.empty       = (rd_src == '0);
    assign o_sts.match       = (rd_src == r_src);
    assign o_sts.at_home     = (r_slot == r_home);
    assign o_sts.last_lookup = (r_count == SLOT_W'(TABLE_DEPTH - 1));
    assign o_sts.insert_stop = (count_inc >= CMP_W'(r_limit))
                            || (count_inc >= CMP_W'(TABLE_DEPTH));
    assign o_sts.clr_last    = (r_clr == SLOT_W'(TABLE_DEPTH - 1));

    // Response register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                camh_pkg::OUT_HIT: begin
                    r_out.found          <= 1'b1;
                    r_out.result_address <= camh_pkg::FIELD_W'(r_hit_dst);
                    r_out.status         <= 1'b0;
                end
                camh_pkg::OUT_FULL: begin
                    r_out.found          <= 1'b0;
                    r_out.result_address <= '0;
                    r_out.status         <= 1'b1;
                end
                default: begin
                    r_out.found          <= 1'b0;
                    r_out.result_address <= '0;
                    r_out.status         <= 1'b0;
                end
            endcase
        end
    end

    assign o_rsp_data = r_out;

endmodule

// File: src/camh_ctrl.sv
// Controller: sequences clearing, hashing, probing, swapping and the response beat.
module camh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_rsp_ready,
    input  camh_pkg::t_dp_sts i_sts,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    output camh_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_ISSUE,
        S_PROBE,
        S_SWAP,
        S_FINISH
    } t_state;

    t_state              r_state;
    t_state              n_state;
    camh_pkg::t_out_kind r_kind;
    camh_pkg::t_out_kind n_kind;
    logic                r_out_valid;
    logic                n_out_valid;
    camh_pkg::t_dp_cmd   cmd;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.wr_sel = camh_pkg::WR_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_HASH1;
                end
            end
            S_HASH1: begin
                // A zero source never hits and never inserts.
                if (i_sts.src_zero) begin
                    n_kind  = camh_pkg::OUT_OK;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_HASH2;
                end
            end
            S_HASH2: begin
                n_state = S_HASH3;
            end
            S_HASH3: begin
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                cmd.probe_start = 1'b1;
                cmd.rd_sel      = camh_pkg::RD_HOME;
                n_state         = S_PROBE;
            end
            S_PROBE: begin
                cmd.probe  = 1'b1;
                cmd.rd_sel = camh_pkg::RD_NEXT;
                if (i_sts.is_insert) begin
                    if (i_sts.empty) begin
                        cmd.wr_sel = camh_pkg::WR_INSERT;
                        n_kind     = camh_pkg::OUT_OK;
                        n_state    = S_FINISH;
                    end else if (i_sts.insert_stop) begin
                        n_kind  = camh_pkg::OUT_FULL;
                        n_state = S_FINISH;
                    end else begin
                        cmd.probe_adv = 1'b1;
                    end
                end else begin
                    if (i_sts.empty) begin
                        n_kind  = camh_pkg::OUT_OK;
                        n_state = S_FINISH;
                    end else if (i_sts.match) begin
                        cmd.cap_hit = 1'b1;
                        n_kind      = camh_pkg::OUT_HIT;
                        if (i_sts.at_home) begin
                            n_state = S_FINISH;
                        end else begin
                            // Hit entry moves home now, home entry moves out next cycle.
                            cmd.wr_sel = camh_pkg::WR_SWAP_HOME;
                            n_state    = S_SWAP;
                        end
                    end else if (i_sts.last_lookup) begin
                        n_kind  = camh_pkg::OUT_OK;
                        n_state = S_FINISH;
                    end else begin
                        cmd.probe_adv = 1'b1;
                    end
                end
            end
            S_SWAP: begin
                cmd.wr_sel = camh_pkg::WR_SWAP_SLOT;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                // Wait until the response register is free or drains this cycle.
                if (!r_out_valid || i_rsp_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = r_kind;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Response valid: set on load, cleared when the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_kind      <= camh_pkg::OUT_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A new response never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_rsp_ready))
        else $error("response loaded over a pending beat");

    // The second half of a swap only follows a hit in the probe state.
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP) |-> ($past(r_state) == S_PROBE)
                             && ($past(cmd.wr_sel) == camh_pkg::WR_SWAP_HOME))
        else $error("swap completion without a preceding home write");

    // The table is never written while a request may be accepted.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> (cmd.wr_sel == camh_pkg::WR_NONE))
        else $error("table write while idle");

    // A pending response is dropped only when it was taken.
    a_valid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_rsp_ready))
        else $error("response dropped without being taken");

endmodule

// File: src/code_address_map_hash_table.sv
// Top level of the code address map hash table: controller, datapath and ports.
//
//   Channel  Direction  Beat contents
//   i_req    in         command, source_address, target_address
//   o_rsp    out        found, result_address, status
//   i_cfg    in         probe_limit write (i_cfg_we, i_cfg_wdata)
//
// After reset a clearing pass writes every table slot to zero in turn,
// while no request is accepted; configuration writes are taken throughout.
// From acceptance to the next acceptance a request passes the home slot hash pipeline
// (two multiplies and a fix-up), the probe issue, the probe of each slot (one per cycle
// on the table read port), the second write of a move-to-front swap if one is made, and
// the response load; a zero source skips the rest of the hash pipeline and the probing.
// A finished response waits in the output register; a stalled sink holds only the
// final step, and a new request is accepted while the last response is still waiting.
module code_address_map_hash_table #(
    parameter int TABLE_DEPTH = camh_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = camh_pkg::ADDR_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [camh_pkg::CFG_W-1:0] i_cfg_wdata,
    camh_stream_if.sink                i_req,
    camh_stream_if.source              o_rsp
);

    camh_pkg::t_dp_cmd cmd;
    camh_pkg::t_dp_sts sts;
    logic              req_ready;
    logic              rsp_valid;
    camh_pkg::t_rsp    rsp_data;

    // Sequencing.
    camh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .o_cmd       (cmd)
    );

    // Table and arithmetic.
    camh_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_data  (i_req.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_data  (rsp_data)
    );

    // Channel handshakes.
    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp_data;

endmodule

// File: tb/sv/code_address_map_hash_table_tb.sv
// Testbench of the code address map hash table: directed and random beats checked by a scoreboard.
module code_address_map_hash_table_tb;
    import camh_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int HOME_W      = $clog2(DEPTH);
    localparam int PHASE_ITEMS = 90;
    localparam int PHASES      = 8;
    localparam int MAX_GAP     = 20;
    localparam int MAX_STALL   = 64;
    localparam int IDLE_PCT    = 66;
    localparam int BOTH_PCT    = 19;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_ITEMS   = 64 + PHASES * PHASE_ITEMS + DEPTH + 64;
    localparam int LIMIT_CYCLES =
        4 * MAX_ITEMS * (DEPTH + 8 + MAX_GAP + MAX_STALL) + 4 * DEPTH;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    camh_stream_if #(.T(t_req)) req_if ();
    camh_stream_if #(.T(t_rsp)) rsp_if ();

    code_address_map_hash_table #(
        .TABLE_DEPTH(DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Scoreboard: a private copy of the table predicts each reply beat in order.
    class addr_map_scoreboard;
        logic [FIELD_W-1:0] slot_source [DEPTH];
        logic [FIELD_W-1:0] slot_target [DEPTH];
        logic [CFG_W-1:0]   probe_limit;
        t_rsp               pending_translations [$];
        int                 errors;
        int                 replies;

        function new();
            for (int s = 0; s < DEPTH; s++) begin
                slot_source[s] = '0;
                slot_target[s] = '0;
            end
            probe_limit = PROBE_LIMIT_RESET;
            errors      = 0;
            replies     = 0;
        endfunction

        function int home_of(logic [FIELD_W-1:0] src);
            return int'((src >> 2) % DEPTH);
        endfunction

        // Apply one accepted request to the table copy and queue its reply.
        function void note_request(t_req req);
            logic [FIELD_W-1:0] src;
            logic [FIELD_W-1:0] held_src;
            logic [FIELD_W-1:0] held_dst;
            t_rsp               want;
            int                 home;
            int                 s;
            int                 probes;
            bit                 done;
            src  = req.source_address;
            want = '0;
            home = home_of(src);
            s    = home;
            done = 1'b0;
            if (req.command == CMD_LOOKUP) begin
                // A lookup walks from home to a match or an empty slot.
                if (src != '0) begin
                    for (probes = 0; probes < DEPTH && !done; probes++) begin
                        if (slot_source[s] == '0) begin
                            done = 1'b1;
                        end else if (slot_source[s] == src) begin
                            // A hit away from home trades places with the home entry.
                            held_src          = slot_source[home];
                            held_dst          = slot_target[home];
                            slot_source[home] = slot_source[s];
                            slot_target[home] = slot_target[s];
                            slot_source[s]    = held_src;
                            slot_target[s]    = held_dst;
                            want.found          = 1'b1;
                            want.result_address = slot_target[home];
                            done = 1'b1;
                        end else begin
                            s = (s + 1) % DEPTH;
                        end
                    end
                end
            end else if (src != '0) begin
                // An insert walks to the first empty slot unless the probe budget runs out.
                probes = 0;
                while (slot_source[s] != '0 && !done) begin
                    s = (s + 1) % DEPTH;
                    probes++;
                    if (probes >= int'(probe_limit) || probes >= DEPTH) begin
                        done = 1'b1;
                    end
                end
                if (done) begin
                    want.status = 1'b1;
                end else begin
                    slot_source[s] = src;
                    slot_target[s] = req.target_address;
                end
            end
            pending_translations.push_back(want);
        endfunction

        task report_mismatch(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
            $display("MISMATCH on reply %0d: %s is 0x%08h, expected 0x%08h",
                     replies, what, got, want);
            errors++;
        endtask

        // Compare one reply beat with the oldest prediction.
        task check_response(t_rsp got);
            t_rsp want;
            if (pending_translations.size() == 0) begin
                report_mismatch("unrequested reply, result_address", got.result_address, '0);
            end else begin
                want = pending_translations.pop_front();
                if (got.found !== want.found) begin
                    report_mismatch("found", 32'(got.found), 32'(want.found));
                end
                if (got.result_address !== want.result_address) begin
                    report_mismatch("result_address", got.result_address, want.result_address);
                end
                if (got.status !== want.status) begin
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
            replies++;
        endtask
    endclass

    addr_map_scoreboard map_sb = new();

    logic [FIELD_W-1:0] known_sources [$];
    logic [HOME_W-1:0]  window_base  = '0;
    int                 src_idle_pct = 0;
    int                 snk_idle_pct = 0;
    int                 cycle_count  = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reply side: ready is redrawn at each falling edge.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Every reply beat goes to the scoreboard.
    always @(posedge i_clk) begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            map_sb.check_response(rsp_if.data);
        end
    end

    // Offer one request beat after a random gap and hold it until it is taken.
    task automatic drive_req(input t_req item);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        map_sb.note_request(item);
        if (item.command == CMD_INSERT && item.source_address != '0) begin
            known_sources.push_back(item.source_address);
        end
        @(negedge i_clk);
    endtask

    task automatic send(input logic cmd, input logic [FIELD_W-1:0] src,
                        input logic [FIELD_W-1:0] dst);
        t_req item;
        item.command        = cmd;
        item.source_address = src;
        item.target_address = dst;
        drive_req(item);
    endtask

    // Stop offering beats until every predicted reply has come back.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (map_sb.pending_translations.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write; only issued while the block is idle.
    task automatic write_probe_limit(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        map_sb.probe_limit = value;
    endtask

    // A random nonzero address whose home slot is the given one.
    function automatic logic [FIELD_W-1:0] at_home(input int home);
        logic [FIELD_W-1:0] v;
        v = $urandom();
        v[HOME_W+1:2] = home[HOME_W-1:0];
        if (v == '0) v[HOME_W+2] = 1'b1;
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] known_source();
        return known_sources[$urandom_range(known_sources.size() - 1)];
    endfunction

    // New addresses: some zero, many crowded into a window, some colliding with known homes.
    function automatic logic [FIELD_W-1:0] fresh_source();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) return '0;
        if (pick < 40) return at_home((int'(window_base) + $urandom_range(63)) % DEPTH);
        if (pick < 60 && known_sources.size() > 0) return at_home(map_sb.home_of(known_source()));
        return $urandom();
    endfunction

    function automatic logic [FIELD_W-1:0] absent_source();
        logic [FIELD_W-1:0] v;
        bit                 clash;
        do begin
            v     = $urandom();
            clash = (v == '0);
            for (int s = 0; s < DEPTH; s++) begin
                if (map_sb.slot_source[s] == v) clash = 1'b1;
            end
        end while (clash);
        return v;
    endfunction

    // Mostly lookups, most of them of stored addresses; inserts now and then repeat one.
    function automatic t_req random_request();
        t_req item;
        item.command        = ($urandom_range(99) < 28) ? CMD_INSERT : CMD_LOOKUP;
        item.target_address = $urandom();
        if (known_sources.size() > 0 &&
            $urandom_range(99) < ((item.command == CMD_INSERT) ? 8 : 55)) begin
            item.source_address = known_source();
        end else begin
            item.source_address = fresh_source();
        end
        return item;
    endfunction

    task automatic run_phase(input int src_pct, input int snk_pct,
                             input logic [CFG_W-1:0] limit, input int count);
        drain();
        write_probe_limit(limit);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        window_base  = HOME_W'($urandom());
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) == 0) drain();
            drive_req(random_request());
        end
    endtask

    // Fill every empty slot through its own home, so each insert lands at once.
    task automatic fill_table();
        for (int s = 0; s < DEPTH; s++) begin
            if (map_sb.slot_source[s] == '0) send(CMD_INSERT, at_home(s), $urandom());
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset probe limit: zero addresses, extremes, wrap and swap.
        send(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send(CMD_INSERT, 32'h0000_0001, 32'h0000_0000);
        send(CMD_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF);
        // Same home as the all-ones address; the probe wraps past the last slot.
        send(CMD_INSERT, 32'h0000_0FFC, 32'hA5A5_5A5A);
        send(CMD_LOOKUP, 32'h0000_0FFC, 32'h0000_0000);
        send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // A duplicate insert lands further along; lookups keep the nearer one.
        send(CMD_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
        send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send(CMD_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        // With a zero or unit probe limit an occupied home refuses the insert.
        drain();
        write_probe_limit('0);
        send(CMD_INSERT, 32'h0000_1FFC, 32'h0BAD_F00D);
        send(CMD_INSERT, 32'h8000_0010, 32'h5555_AAAA);
        send(CMD_LOOKUP, 32'h0000_1FFC, 32'h0000_0000);
        drain();
        write_probe_limit(CFG_W'(1));
        send(CMD_INSERT, 32'h0000_2004, 32'h1111_2222);
        send(CMD_INSERT, 32'h4000_0020, 32'h3333_4444);
        drain();
        write_probe_limit(CFG_W'(2047));
        send(CMD_INSERT, 32'h0000_3FFC, 32'h7777_8888);
        send(CMD_LOOKUP, 32'h0000_3FFC, 32'h0000_0000);
        send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

        // Random phases over idling patterns and probe limits.
        run_phase(0,        0,        PROBE_LIMIT_RESET, PHASE_ITEMS);
        run_phase(IDLE_PCT, 0,        CFG_W'(1),         PHASE_ITEMS);
        run_phase(0,        IDLE_PCT, CFG_W'(2047),      PHASE_ITEMS);
        run_phase(BOTH_PCT, BOTH_PCT, '0,                PHASE_ITEMS);
        run_phase(0,        0,        CFG_W'($urandom_range(2, 40)), PHASE_ITEMS);
        run_phase(BOTH_PCT, BOTH_PCT, CFG_W'(1024),      PHASE_ITEMS);
        run_phase(IDLE_PCT, 0,        CFG_W'($urandom_range(2, 64)), PHASE_ITEMS);
        run_phase(0,        IDLE_PCT, CFG_W'(5),         PHASE_ITEMS);

        // Full table: a miss probes every slot and an insert runs out of slots.
        drain();
        write_probe_limit(CFG_W'(2047));
        src_idle_pct = 0;
        snk_idle_pct = IDLE_PCT;
        fill_table();
        send(CMD_LOOKUP, absent_source(), $urandom());
        send(CMD_LOOKUP, absent_source(), $urandom());
        send(CMD_INSERT, absent_source(), $urandom());
        send(CMD_INSERT, 32'h0000_0000, $urandom());
        drain();
        write_probe_limit(CFG_W'(1024));
        src_idle_pct = BOTH_PCT;
        snk_idle_pct = BOTH_PCT;
        send(CMD_INSERT, absent_source(), $urandom());
        for (int n = 0; n < 24; n++) begin
            if (n == 12) begin
                send(CMD_LOOKUP, 32'h0000_0000, $urandom());
            end else begin
                send(CMD_LOOKUP, known_source(), $urandom());
            end
        end

        // Let the last replies arrive, then give the verdict.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (map_sb.errors == 0 && map_sb.pending_translations.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
